FILE: design/mltt_pkg.sv
// Shared constants and types of the minimum-latency line tour block.
package mltt_pkg;

   localparam int MAX_POINTS_DEF    = 64;
   localparam int POSITION_BITS_DEF = 16;
   localparam int FIELD_BITS        = 16;
   localparam int COST_BITS         = 31;

   localparam logic [COST_BITS-1:0] COST_CAP = {COST_BITS{1'b1}};

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_COPY,
      ST_R1,
      ST_R2,
      ST_MUL,
      ST_ADD,
      ST_FIN1,
      ST_FIN2
   } back_state_type;

endpackage

FILE: design/min_latency_line_tour.sv
// Top level of the minimum-latency line tour block.
// Point positions arrive one transfer per cycle on the req_ channel while the
// queue has room, and are sorted into a row of insertion cells as they come;
// the transfer flagged with req_last_point closes the set, and the start
// position held in the csr_ register is sorted in as well. At most MAX_POINTS
// points are kept per set; further points are dropped but their last flag
// still closes the set. The engine then runs the interval program on
// m = points + 1 positions: it sorts the start in, moves the sorted list into
// the position memory, runs each of (m-1)(m+2)/2 span steps through two reads,
// a multiply stage and an add-and-compare stage, and fetches the cost into the
// result register once that register is free. While the engine works, the
// front end still takes up to two transfers of the next set into its queue.
// The minimum total waiting cost is held on rsp_total_cost until its transfer
// completes, and partial costs saturate at 2^31-1. The csr_ channel is always
// ready and should be written only while the block is idle.
module min_latency_line_tour #(
   parameter int MAX_POINTS    = mltt_pkg::MAX_POINTS_DEF,
   parameter int POSITION_BITS = mltt_pkg::POSITION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mltt_pkg::FIELD_BITS-1:0]    req_point_position,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mltt_pkg::COST_BITS-1:0]     rsp_total_cost,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mltt_pkg::FIELD_BITS-1:0]    csr_start_position
);

   localparam int QW = POSITION_BITS + 2;

   logic [mltt_pkg::FIELD_BITS-1:0] start_position_ff;
   logic                            fq_valid, fq_ready;
   logic [QW-1:0]                   fq_data;
   logic                            qb_valid, qb_ready;
   logic [QW-1:0]                   qb_data;

   // The start register takes a write in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_position_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         start_position_ff <= csr_start_position;
      end
   end

   // Front end marks each point as kept or dropped and whether it ends the set.
   mltt_front #(
      .MAX_POINTS    (MAX_POINTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point_position (req_point_position),
      .req_last_point     (req_last_point),
      .q_valid            (fq_valid),
      .q_ready            (fq_ready),
      .q_data             (fq_data)
   );

   // The queue lets the front end keep taking transfers while the engine is busy.
   mltt_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   // The engine sorts, runs the span program and holds the result.
   mltt_back #(
      .MAX_POINTS    (MAX_POINTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (qb_valid),
      .in_ready       (qb_ready),
      .in_data        (qb_data),
      .start_position (POSITION_BITS'(start_position_ff)),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_total_cost (rsp_total_cost)
   );

endmodule

FILE: design/mltt_front.sv
// Front end: accepts points, masks them and marks the ones beyond capacity.
module mltt_front #(
   parameter int MAX_POINTS    = mltt_pkg::MAX_POINTS_DEF,
   parameter int POSITION_BITS = mltt_pkg::POSITION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mltt_pkg::FIELD_BITS-1:0]      req_point_position,
   input  logic                                 req_last_point,
   output logic                                 q_valid,
   input  logic                                 q_ready,
   output logic [POSITION_BITS+1:0]             q_data
);

   localparam int CW = $clog2(MAX_POINTS + 2);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          keep;
   logic          fire;

   assign keep      = count_ff < CW'(MAX_POINTS);
   assign fire      = req_valid && req_ready;
   assign req_ready = q_ready;
   assign q_valid   = req_valid;
   assign q_data    = {POSITION_BITS'(req_point_position), keep, req_last_point};

   always_comb begin
      count_in = count_ff;
      if (fire) begin
         if (req_last_point) begin
            count_in = '0;
         end else if (keep) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/mltt_queue.sv
// Two-entry queue between the front end and the tour engine.
module mltt_queue #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       fill_ff;
   logic             push;
   logic             pop;

   assign wr_ready = fill_ff != 2'd2;
   assign rd_valid = fill_ff != 2'd0;
   assign rd_data  = data_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: design/mltt_back.sv
// Tour engine: sorted insertion cells, position and cost memories, interval DP.
module mltt_back #(
   parameter int MAX_POINTS    = mltt_pkg::MAX_POINTS_DEF,
   parameter int POSITION_BITS = mltt_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [POSITION_BITS+1:0]            in_data,
   input  logic [POSITION_BITS-1:0]            start_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mltt_pkg::COST_BITS-1:0]      rsp_total_cost
);

   localparam int SLOTS = MAX_POINTS + 1;
   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int PB    = POSITION_BITS;
   localparam int PW    = PB + CW;
   localparam int KB    = mltt_pkg::COST_BITS;
   localparam int SW    = ((PW > KB) ? PW : KB) + 1;

   mltt_pkg::back_state_type state_ff, state_in;

   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] m_ff, m_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] l_ff, l_in;
   logic          layer_ff, layer_in;
   logic [IW-1:0] sidx_ff, sidx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [KB-1:0] rsp_cost_ff;

   logic [PB-1:0] cell_ff [SLOTS];
   logic          flag_ff [SLOTS];

   logic [PB-1:0] pos_mem [2**IW];
   logic [PB-1:0] pos_rd_a_ff, pos_rd_b_ff;
   logic [IW-1:0] pos_addr_a, pos_addr_b;
   logic [KB-1:0] cost0_mem [2**(IW+1)];
   logic [KB-1:0] cost1_mem [2**(IW+1)];
   logic [KB-1:0] cost0_rd_ff, cost1_rd_ff;
   logic [IW:0]   cost0_raddr, cost1_raddr, cost_waddr;
   logic          cost_we;
   logic [KB-1:0] cost0_wdata, cost1_wdata;

   logic [PB-1:0] pa_ff, pb_ff;
   logic [KB-1:0] c0_ff, c1_ff;
   logic [PW-1:0] p0l_ff, p0r_ff, p1l_ff, p1r_ff;

   logic [PB-1:0] in_pos;
   logic          in_keep, in_last, in_fire;
   logic          do_insert, do_shift;
   logic [PB-1:0] ins_v;
   logic          ins_f;
   logic          left_ok, right_ok;
   logic [CW-1:0] unvisited;
   logic [CW-1:0] r_idx;
   logic          load_rsp;
   logic [SW-1:0] best0, best1, s0l, s0r, s1l, s1r;

   assign in_pos  = in_data[PB+1:2];
   assign in_keep = in_data[1];
   assign in_last = in_data[0];
   assign in_ready = state_ff == mltt_pkg::ST_LOAD;
   assign in_fire  = in_valid && in_ready;

   assign do_insert = (in_fire && in_keep) || (state_ff == mltt_pkg::ST_START);
   assign do_shift  = state_ff == mltt_pkg::ST_COPY;
   assign ins_v     = (state_ff == mltt_pkg::ST_START) ? start_position : in_pos;
   assign ins_f     = state_ff == mltt_pkg::ST_START;

   // Insertion cells: each compares against the new value and keeps, shifts or takes it.
   logic gt [SLOTS];
   genvar j;
   for (j = 0; j < SLOTS; j++) begin : g_cell
      logic          below;
      logic          prev_gt;
      logic [PB-1:0] prev_c, next_c, ins_c;
      logic          prev_f, next_f, ins_fl;

      assign below = CW'(j) < n_ff;
      assign gt[j] = below && (cell_ff[j] > ins_v);

      if (j == 0) begin : g_first
         assign prev_gt = 1'b0;
         assign prev_c  = ins_v;
         assign prev_f  = ins_f;
      end else begin : g_rest
         assign prev_gt = gt[j-1];
         assign prev_c  = cell_ff[j-1];
         assign prev_f  = flag_ff[j-1];
      end

      if (j == SLOTS - 1) begin : g_top
         assign next_c = cell_ff[j];
         assign next_f = flag_ff[j];
      end else begin : g_mid
         assign next_c = cell_ff[j+1];
         assign next_f = flag_ff[j+1];
      end

      always_comb begin
         if (below && !gt[j]) begin
            ins_c  = cell_ff[j];
            ins_fl = flag_ff[j];
         end else if (prev_gt) begin
            ins_c  = prev_c;
            ins_fl = prev_f;
         end else if (CW'(j) <= n_ff) begin
            ins_c  = ins_v;
            ins_fl = ins_f;
         end else begin
            ins_c  = cell_ff[j];
            ins_fl = flag_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (do_insert) begin
            cell_ff[j] <= ins_c;
            flag_ff[j] <= ins_fl;
         end else if (do_shift) begin
            cell_ff[j] <= next_c;
            flag_ff[j] <= next_f;
         end
      end
   end

   assign unvisited = m_ff - len_ff;
   assign r_idx     = l_ff + len_ff - CW'(1);
   assign left_ok   = l_ff != '0;
   assign right_ok  = (l_ff + len_ff) < m_ff;

   // Memory addressing.
   always_comb begin
      pos_addr_a  = IW'(l_ff - CW'(1));
      pos_addr_b  = IW'(l_ff);
      if (state_ff == mltt_pkg::ST_R2) begin
         pos_addr_a = IW'(r_idx);
         pos_addr_b = IW'(r_idx + CW'(1));
      end
      cost0_raddr = {layer_ff, sidx_ff};
      if (state_ff == mltt_pkg::ST_R1) begin
         cost0_raddr = {layer_ff, IW'(l_ff - CW'(1))};
      end
      cost1_raddr = {layer_ff, IW'(l_ff)};
   end

   always_ff @(posedge clock) begin
      if (do_shift) begin
         pos_mem[IW'(k_ff)] <= cell_ff[0];
      end
      pos_rd_a_ff <= pos_mem[pos_addr_a];
      pos_rd_b_ff <= pos_mem[pos_addr_b];
   end

   // Candidate sums and minimum for both ends of the span.
   always_comb begin
      s0l   = SW'(p0l_ff) + SW'(c0_ff);
      s0r   = SW'(p0r_ff) + SW'(c1_ff);
      s1l   = SW'(p1l_ff) + SW'(c0_ff);
      s1r   = SW'(p1r_ff) + SW'(c1_ff);
      best0 = SW'(mltt_pkg::COST_CAP);
      best1 = SW'(mltt_pkg::COST_CAP);
      if (left_ok && s0l < best0) begin
         best0 = s0l;
      end
      if (right_ok && s0r < best0) begin
         best0 = s0r;
      end
      if (left_ok && s1l < best1) begin
         best1 = s1l;
      end
      if (right_ok && s1r < best1) begin
         best1 = s1r;
      end
   end

   always_comb begin
      cost_we     = 1'b0;
      cost_waddr  = {~layer_ff, IW'(l_ff)};
      cost0_wdata = KB'(best0);
      cost1_wdata = KB'(best1);
      if (state_ff == mltt_pkg::ST_START) begin
         cost_we     = 1'b1;
         cost_waddr  = '0;
         cost0_wdata = '0;
         cost1_wdata = '0;
      end else if (state_ff == mltt_pkg::ST_ADD) begin
         cost_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost0_mem[cost_waddr] <= cost0_wdata;
         cost1_mem[cost_waddr] <= cost1_wdata;
      end
      cost0_rd_ff <= cost0_mem[cost0_raddr];
      cost1_rd_ff <= cost1_mem[cost1_raddr];
   end

   // Datapath registers of one span step.
   always_ff @(posedge clock) begin
      if (state_ff == mltt_pkg::ST_R2) begin
         pa_ff <= pos_rd_a_ff;
         pb_ff <= pos_rd_b_ff;
         c0_ff <= cost0_rd_ff;
         c1_ff <= cost1_rd_ff;
      end
      if (state_ff == mltt_pkg::ST_MUL) begin
         p0l_ff <= PW'(pb_ff - pa_ff) * PW'(unvisited);
         p1l_ff <= PW'(pos_rd_a_ff - pa_ff) * PW'(unvisited);
         p0r_ff <= PW'(pos_rd_b_ff - pb_ff) * PW'(unvisited);
         p1r_ff <= PW'(pos_rd_b_ff - pos_rd_a_ff) * PW'(unvisited);
      end
      if (load_rsp) begin
         rsp_cost_ff <= cost0_rd_ff;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      l_in         = l_ff;
      layer_in     = layer_ff;
      sidx_in      = sidx_ff;
      load_rsp     = 1'b0;
      case (state_ff)
         mltt_pkg::ST_LOAD: begin
            if (in_fire) begin
               if (in_keep) begin
                  n_in = n_ff + CW'(1);
               end
               if (in_last) begin
                  state_in = mltt_pkg::ST_START;
               end
            end
         end
         mltt_pkg::ST_START: begin
            m_in     = n_ff + CW'(1);
            k_in     = '0;
            layer_in = 1'b0;
            state_in = mltt_pkg::ST_COPY;
         end
         mltt_pkg::ST_COPY: begin
            k_in = k_ff + CW'(1);
            if (flag_ff[0]) begin
               sidx_in = IW'(k_ff);
            end
            if (k_ff == m_ff - CW'(1)) begin
               n_in     = '0;
               len_in   = m_ff - CW'(1);
               l_in     = '0;
               state_in = mltt_pkg::ST_R1;
            end
         end
         mltt_pkg::ST_R1: begin
            state_in = mltt_pkg::ST_R2;
         end
         mltt_pkg::ST_R2: begin
            state_in = mltt_pkg::ST_MUL;
         end
         mltt_pkg::ST_MUL: begin
            state_in = mltt_pkg::ST_ADD;
         end
         mltt_pkg::ST_ADD: begin
            if (right_ok) begin
               l_in     = l_ff + CW'(1);
               state_in = mltt_pkg::ST_R1;
            end else begin
               layer_in = ~layer_ff;
               l_in     = '0;
               if (len_ff == CW'(1)) begin
                  state_in = mltt_pkg::ST_FIN1;
               end else begin
                  len_in   = len_ff - CW'(1);
                  state_in = mltt_pkg::ST_R1;
               end
            end
         end
         mltt_pkg::ST_FIN1: begin
            state_in = mltt_pkg::ST_FIN2;
         end
         mltt_pkg::ST_FIN2: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = mltt_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mltt_pkg::ST_LOAD;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mltt_pkg::ST_LOAD;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      k_ff     <= k_in;
      len_ff   <= len_in;
      l_ff     <= l_in;
      layer_ff <= layer_in;
      sidx_ff  <= sidx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_cost = rsp_cost_ff;

endmodule

FILE: design/mltt_checker.sv
// Port checks of the minimum-latency line tour block and their binding.
module mltt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [mltt_pkg::COST_BITS-1:0]     rsp_total_cost
);

   // Reset empties the result register.
   a_reset_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result still offered after reset");

   // Reset empties the input queue, so the block takes a transfer at once.
   a_reset_req : assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // A stalled result holds its cost.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_cost))
      else $error("stalled result changed");

endmodule

bind min_latency_line_tour mltt_checker u_mltt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_total_cost (rsp_total_cost)
);
